// File: design/rsmrp_pkg.sv
package rsmrp_pkg;

   // Field widths
   localparam int SAMPLE_W  = 16;
   localparam int PEAK_W    = 15;
   localparam int POS_W     = 32;
   localparam int LEN_W     = 24;
   localparam int CMD_W     = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [PEAK_W-1:0] PEAK_MAX = '1;
   localparam logic [POS_W-1:0]  POS_MAX  = '1;

   // Register indexes (byte address is 4 * index)
   localparam logic [1:0] REG_MUTE   = 2'd0;
   localparam logic [1:0] REG_RAMP   = 2'd1;
   localparam logic [1:0] REG_STEREO = 2'd2;

   // Command codes on the input word
   localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PEAK    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

   // Classified command, decided by the front part
   typedef enum logic [1:0] {
      KIND_SAMPLE,
      KIND_PEAK,
      KIND_RESTART,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type                    kind;
      logic signed [SAMPLE_W-1:0]  sample;
   } item_type;

   typedef struct packed {
      logic [LEN_W-1:0] mute;
      logic [LEN_W-1:0] ramp;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_FIN
   } state_type;

endpackage

// File: design/recording_start_mute_ramp_peak.sv
// A word passes the input queue and the registered output; a ramp sample that reuses
// the held gain also passes ST_MUL and ST_FIN, and one that recomputes it ST_DIV first.
// Throughput: one word per cycle outside the ramp unless the output stalls; inside
// it the serial divider (one quotient bit per cycle, every fourth ramp sample) and
// multiply stage set the rate. Reset is synchronous: queues empty, position, gain,
// peak and tracking cleared, registers back to mute 0, ramp 1, mono.
module recording_start_mute_ramp_peak
   import rsmrp_pkg::*;
#(
   parameter int GAIN_FRACTION_BITS = 14
)
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_push,
   output logic                        req_full,
   input  logic [CMD_W-1:0]            req_command,
   input  logic signed [SAMPLE_W-1:0]  req_sample_in,

   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic signed [SAMPLE_W-1:0]  rsp_sample_out,
   output logic [PEAK_W-1:0]           rsp_peak_value,
   output logic                        rsp_in_ramp,

   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [CSR_DATA_W-1:0]       csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   logic [LEN_W-1:0] mute_ff, mute_in;
   logic [LEN_W-1:0] ramp_ff, ramp_in;
   logic             stereo_ff, stereo_in;
   logic             csr_write;
   logic [1:0]       csr_index;
   cfg_type          cfg;
   item_type         head;
   logic             head_valid;
   logic             take;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   // Write registers; unknown addresses drop the write
   always_comb begin
      mute_in   = mute_ff;
      ramp_in   = ramp_ff;
      stereo_in = stereo_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_MUTE:   mute_in   = csr_pwdata[LEN_W-1:0];
            REG_RAMP:   ramp_in   = csr_pwdata[LEN_W-1:0];
            REG_STEREO: stereo_in = csr_pwdata[0];
            default:    mute_in   = mute_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mute_ff   <= '0;
         ramp_ff   <= LEN_W'(1);
         stereo_ff <= 1'b0;
      end else begin
         mute_ff   <= mute_in;
         ramp_ff   <= ramp_in;
         stereo_ff <= stereo_in;
      end
   end

   // Read back registers
   always_comb begin
      unique case (csr_index)
         REG_MUTE:   csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, mute_ff};
         REG_RAMP:   csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, ramp_ff};
         REG_STEREO: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, stereo_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg.mute = mute_ff;
   assign cfg.ramp = ramp_ff;

   rsmrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .command    (req_command),
      .sample_in  (req_sample_in),
      .full       (req_full),
      .head       (head),
      .head_valid (head_valid),
      .take       (take)
   );

   rsmrp_back #(
      .FRAC_BITS (GAIN_FRACTION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .head_valid (head_valid),
      .take       (take),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .sample_out (rsp_sample_out),
      .peak_value (rsp_peak_value),
      .in_ramp    (rsp_in_ramp)
   );

endmodule

// File: design/rsmrp_front.sv
module rsmrp_front
   import rsmrp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [CMD_W-1:0]           command,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   output logic                       full,
   output item_type                   head,
   output logic                       head_valid,
   input  logic                       take
);

   localparam int DEPTH = 2;

   item_type    slot_ff [DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        accept;
   item_type    new_item;

   // Classify the incoming command
   always_comb begin
      new_item.sample = sample_in;
      unique case (command)
         CMD_SAMPLE:  new_item.kind = KIND_SAMPLE;
         CMD_PEAK:    new_item.kind = KIND_PEAK;
         CMD_RESTART: new_item.kind = KIND_RESTART;
         default:     new_item.kind = KIND_NOP;
      endcase
   end

   assign full       = (count_ff == 2'(DEPTH));
   assign accept     = push && !full;
   assign head_valid = (count_ff != 2'd0);
   assign head       = slot_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      priority if (accept && !take) begin
         count_in = count_ff + 2'd1;
      end else if (take && !accept) begin
         count_in = count_ff - 2'd1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified word
   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: design/rsmrp_div.sv
module rsmrp_div
   import rsmrp_pkg::*;
#(
   parameter int FRAC_BITS = 14
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [LEN_W-1:0]     dividend,
   input  logic [LEN_W-1:0]     divisor,
   output logic                 done,
   output logic [FRAC_BITS-1:0] quotient
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 done_ff, done_in;
   logic [LEN_W-1:0]     rem_ff, rem_in;
   logic [LEN_W-1:0]     dvs_ff, dvs_in;
   logic [FRAC_BITS-1:0] quot_ff, quot_in;
   logic [LEN_W:0]       rem2;
   logic [LEN_W:0]       diff;
   logic                 fits;

   // One quotient bit per cycle; remainder stays below the divisor
   always_comb begin
      rem2 = {rem_ff, 1'b0};
      diff = rem2 - {1'b0, dvs_ff};
      fits = (rem2 >= {1'b0, dvs_ff});

      count_in = count_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quot_in  = quot_ff;
      priority if (start) begin
         count_in = CNT_W'(FRAC_BITS);
         rem_in   = dividend;
         dvs_in   = divisor;
         quot_in  = '0;
      end else if (count_ff != '0) begin
         count_in = count_ff - CNT_W'(1);
         done_in  = (count_ff == CNT_W'(1));
         rem_in   = fits ? diff[LEN_W-1:0] : rem2[LEN_W-1:0];
         quot_in  = {quot_ff[FRAC_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: design/rsmrp_back.sv
module rsmrp_back
   import rsmrp_pkg::*;
#(
   parameter int FRAC_BITS = 14
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  item_type                    head,
   input  logic                        head_valid,
   output logic                        take,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic signed [SAMPLE_W-1:0]  sample_out,
   output logic [PEAK_W-1:0]           peak_value,
   output logic                        in_ramp
);

   localparam int PROD_W = SAMPLE_W + FRAC_BITS + 1;

   state_type                   state_ff, state_in;
   logic [POS_W-1:0]            pos_ff, pos_in;
   logic [FRAC_BITS-1:0]        gain_ff, gain_in;
   logic [PEAK_W-1:0]           peak_ff, peak_in;
   logic                        track_ff, track_in;
   logic signed [PROD_W-1:0]    prod_ff;
   logic                        out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0]  out_sample_ff;
   logic [PEAK_W-1:0]           out_peak_ff;
   logic                        out_ramp_ff;

   logic [POS_W-1:0]            mute_ext;
   logic [POS_W-1:0]            ramp_ext;
   logic [POS_W-1:0]            offset;
   logic                        muted;
   logic                        ramp_zone;
   logic signed [PROD_W-1:0]    prod_shift;
   logic                        out_free;
   logic                        finish;
   logic signed [SAMPLE_W-1:0]  fin_sample;
   logic [PEAK_W-1:0]           fin_peak;
   logic                        fin_ramp;
   logic [PEAK_W-1:0]           fin_abs;
   logic                        div_start;
   logic                        div_done;
   logic [FRAC_BITS-1:0]        div_quot;

   rsmrp_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (offset[LEN_W-1:0]),
      .divisor  (cfg.ramp),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Locate the current sample within mute and ramp
   always_comb begin
      mute_ext   = {{(POS_W-LEN_W){1'b0}}, cfg.mute};
      ramp_ext   = {{(POS_W-LEN_W){1'b0}}, cfg.ramp};
      muted      = (pos_ff < mute_ext);
      offset     = pos_ff - mute_ext;
      ramp_zone  = !muted && (offset < ramp_ext);
      prod_shift = prod_ff >>> FRAC_BITS;
      out_free   = !out_valid_ff || rsp_pop;
   end

   // Sequence one word: classify; for ramp samples divide (every fourth) and multiply; deliver
   always_comb begin
      state_in   = state_ff;
      finish     = 1'b0;
      fin_sample = '0;
      fin_peak   = '0;
      fin_ramp   = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               unique case (head.kind)
                  KIND_SAMPLE: begin
                     if (ramp_zone) begin
                        if (offset[1:0] == 2'd0) begin
                           div_start = 1'b1;
                           state_in  = ST_DIV;
                        end else begin
                           state_in  = ST_MUL;
                        end
                     end else if (out_free) begin
                        finish     = 1'b1;
                        fin_sample = muted ? '0 : head.sample;
                        fin_ramp   = muted;
                     end
                  end
                  KIND_PEAK: begin
                     finish   = out_free;
                     fin_peak = peak_ff;
                  end
                  KIND_RESTART, KIND_NOP: begin
                     finish = out_free;
                  end
                  default: begin
                     finish = out_free;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               finish     = 1'b1;
               fin_sample = prod_shift[SAMPLE_W-1:0];
               fin_ramp   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign take = finish;

   // Saturating magnitude for the peak meter
   always_comb begin
      priority if (!fin_sample[SAMPLE_W-1]) begin
         fin_abs = fin_sample[PEAK_W-1:0];
      end else if (fin_sample[PEAK_W-1:0] == '0) begin
         fin_abs = PEAK_MAX;
      end else begin
         fin_abs = PEAK_W'(-fin_sample);
      end
   end

   // Update position, gain, peak and tracking
   always_comb begin
      pos_in       = pos_ff;
      gain_in      = gain_ff;
      peak_in      = peak_ff;
      track_in     = track_ff;
      out_valid_in = out_valid_ff;
      if (state_ff == ST_DIV && div_done) begin
         gain_in = div_quot;
      end
      if (finish) begin
         out_valid_in = 1'b1;
         unique case (head.kind)
            KIND_SAMPLE: begin
               if (pos_ff != POS_MAX) begin
                  pos_in = pos_ff + POS_W'(1);
               end
               if (track_ff && (fin_abs > peak_ff)) begin
                  peak_in = fin_abs;
               end
            end
            KIND_PEAK: begin
               track_in = 1'b1;
               peak_in  = '0;
            end
            KIND_RESTART: begin
               pos_in   = '0;
               gain_in  = '0;
               peak_in  = '0;
               track_in = 1'b0;
            end
            default: begin
               pos_in = pos_ff;
            end
         endcase
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         gain_ff      <= '0;
         peak_ff      <= '0;
         track_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         gain_ff      <= gain_in;
         peak_ff      <= peak_in;
         track_ff     <= track_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the product and the delivered word
   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff <= head.sample * $signed({1'b0, gain_ff});
      end
      if (finish) begin
         out_sample_ff <= fin_sample;
         out_peak_ff   <= fin_peak;
         out_ramp_ff   <= fin_ramp;
      end
   end

   assign rsp_empty  = !out_valid_ff;
   assign sample_out = out_sample_ff;
   assign peak_value = out_peak_ff;
   assign in_ramp    = out_ramp_ff;

endmodule
